// ===== rtl/core/strongly_connected_components_defines.svh =====
// Assertion macros for the SCC block.
`ifndef STRONGLY_CONNECTED_COMPONENTS_DEFINES_SVH
`define STRONGLY_CONNECTED_COMPONENTS_DEFINES_SVH

// same-cycle implication
`define SCC_ASSERT_NOW(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("scc check failed");

// next-cycle implication
`define SCC_ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("scc check failed");

`endif

// ===== rtl/core/scc_pkg.sv =====
package scc_pkg;

	localparam int CMD_W       = 2;
	localparam int VTX_W       = 9;
	localparam int ID_W        = 8;
	localparam int TOTAL_W     = 9;
	localparam int STATUS_W    = 2;
	localparam int CFG_W       = 9;
	localparam int S_TDATA_W   = 24;
	localparam int M_TDATA_W   = 24;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_ADD     = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_QUERY   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_NOT_READY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_ADD_WR,
		S_QRY,
		S_P1_ROOT,
		S_P1_LOAD,
		S_P1_SCAN,
		S_P1_POP,
		S_P2_NEXT,
		S_P2_FIN,
		S_P2_VISIT,
		S_P2_SCAN,
		S_P2_POP
	} state_t;

	typedef struct packed {
		logic    take;
		logic    invalidate;
		logic    clr_start;
		logic    clr_step;
		logic    add_rd;
		logic    add_wr;
		logic    qry_rd;
		logic    resp;
		logic    resp_qry;
		status_t resp_st;
		logic    p1_init;
		logic    root_skip;
		logic    root_start;
		logic    row_rd;
		logic    scan_step;
		logic    p1_push;
		logic    p1_finish;
		logic    pop_rd;
		logic    p1_restore;
		logic    p2_init;
		logic    fin_rd;
		logic    p2_root;
		logic    p2_visit;
		logic    p2_push;
		logic    p2_take;
		logic    cc_inc;
		logic    done;
	} dp_cmd_t;

	typedef struct packed {
		logic a_ok;
		logic ab_ok;
		logic rv;
		logic out_busy;
		logic clr_last;
		logic root_end;
		logic root_vis;
		logic scan_end;
		logic hit_rev;
		logic hit_fwd;
		logic sp_zero;
		logic idx_zero;
		logic fin_vis;
	} dp_sts_t;

endpackage

// ===== rtl/core/scc_ctrl.sv =====
`include "strongly_connected_components_defines.svh"

module scc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  scc_pkg::cmd_t     op,
	input  scc_pkg::dp_sts_t  sts,
	output logic              in_ready,
	output scc_pkg::dp_cmd_t  cmd
);

	scc_pkg::state_t state_q, state_d;
	logic clr_cmd_q, clr_cmd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= scc_pkg::S_CLR;
			clr_cmd_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_cmd_q <= clr_cmd_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		clr_cmd_d = clr_cmd_q;
		cmd       = '0;
		cmd.resp_st = scc_pkg::ST_OK;
		in_ready  = 1'b0;
		case (state_q)
			scc_pkg::S_IDLE: begin
				in_ready = !sts.out_busy;
				if (in_valid && !sts.out_busy) begin
					cmd.take = 1'b1;
					case (op)
						scc_pkg::CMD_CLEAR: begin
							cmd.invalidate = 1'b1;
							cmd.clr_start  = 1'b1;
							clr_cmd_d      = 1'b1;
							state_d        = scc_pkg::S_CLR;
						end
						scc_pkg::CMD_ADD: begin
							if (sts.ab_ok) begin
								cmd.invalidate = 1'b1;
								cmd.add_rd     = 1'b1;
								state_d        = scc_pkg::S_ADD_WR;
							end else begin
								cmd.resp    = 1'b1;
								cmd.resp_st = scc_pkg::ST_RANGE;
							end
						end
						scc_pkg::CMD_COMPUTE: begin
							cmd.p1_init = 1'b1;
							state_d     = scc_pkg::S_P1_ROOT;
						end
						scc_pkg::CMD_QUERY: begin
							if (!sts.a_ok) begin
								cmd.resp    = 1'b1;
								cmd.resp_st = scc_pkg::ST_RANGE;
							end else if (!sts.rv) begin
								cmd.resp    = 1'b1;
								cmd.resp_st = scc_pkg::ST_NOT_READY;
							end else begin
								cmd.qry_rd = 1'b1;
								state_d    = scc_pkg::S_QRY;
							end
						end
						default: ;
					endcase
				end
			end
			scc_pkg::S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					cmd.resp  = clr_cmd_q;
					clr_cmd_d = 1'b0;
					state_d   = scc_pkg::S_IDLE;
				end
			end
			scc_pkg::S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				cmd.resp   = 1'b1;
				state_d    = scc_pkg::S_IDLE;
			end
			scc_pkg::S_QRY: begin
				cmd.resp     = 1'b1;
				cmd.resp_qry = 1'b1;
				state_d      = scc_pkg::S_IDLE;
			end
			scc_pkg::S_P1_ROOT: begin
				if (sts.root_end) begin
					cmd.p2_init = 1'b1;
					state_d     = scc_pkg::S_P2_NEXT;
				end else if (sts.root_vis) begin
					cmd.root_skip = 1'b1;
				end else begin
					cmd.root_start = 1'b1;
					state_d        = scc_pkg::S_P1_LOAD;
				end
			end
			scc_pkg::S_P1_LOAD: begin
				cmd.row_rd = 1'b1;
				state_d    = scc_pkg::S_P1_SCAN;
			end
			scc_pkg::S_P1_SCAN: begin
				if (sts.scan_end) begin
					cmd.p1_finish = 1'b1;
					if (sts.sp_zero) begin
						cmd.root_skip = 1'b1;
						state_d       = scc_pkg::S_P1_ROOT;
					end else begin
						cmd.pop_rd = 1'b1;
						state_d    = scc_pkg::S_P1_POP;
					end
				end else if (sts.hit_rev) begin
					cmd.p1_push = 1'b1;
					state_d     = scc_pkg::S_P1_LOAD;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			scc_pkg::S_P1_POP: begin
				cmd.p1_restore = 1'b1;
				state_d        = scc_pkg::S_P1_LOAD;
			end
			scc_pkg::S_P2_NEXT: begin
				if (sts.idx_zero) begin
					cmd.done = 1'b1;
					cmd.resp = 1'b1;
					state_d  = scc_pkg::S_IDLE;
				end else begin
					cmd.fin_rd = 1'b1;
					state_d    = scc_pkg::S_P2_FIN;
				end
			end
			scc_pkg::S_P2_FIN: begin
				if (sts.fin_vis) begin
					state_d = scc_pkg::S_P2_NEXT;
				end else begin
					cmd.p2_root = 1'b1;
					state_d     = scc_pkg::S_P2_VISIT;
				end
			end
			scc_pkg::S_P2_VISIT: begin
				cmd.p2_visit = 1'b1;
				cmd.row_rd   = 1'b1;
				state_d      = scc_pkg::S_P2_SCAN;
			end
			scc_pkg::S_P2_SCAN: begin
				if (sts.scan_end) begin
					if (sts.sp_zero) begin
						cmd.cc_inc = 1'b1;
						state_d    = scc_pkg::S_P2_NEXT;
					end else begin
						cmd.pop_rd = 1'b1;
						state_d    = scc_pkg::S_P2_POP;
					end
				end else if (sts.hit_fwd) begin
					cmd.p2_push = 1'b1;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			scc_pkg::S_P2_POP: begin
				cmd.p2_take = 1'b1;
				state_d     = scc_pkg::S_P2_VISIT;
			end
			default: state_d = scc_pkg::S_IDLE;
		endcase
	end

	// a result never lands on a full output register
	`SCC_ASSERT_NOW(a_resp_free, cmd.resp, !sts.out_busy)
	// compute ends back in idle
	`SCC_ASSERT_NEXT(a_done_idle, cmd.done, state_q == scc_pkg::S_IDLE)
	// every new walk starts from an empty stack
	`SCC_ASSERT_NOW(a_p1_root_empty, state_q == scc_pkg::S_P1_ROOT, sts.sp_zero)
	`SCC_ASSERT_NOW(a_p2_root_empty, state_q == scc_pkg::S_P2_NEXT, sts.sp_zero)

endmodule

// ===== rtl/core/scc_dp.sv =====
module scc_dp #(
	parameter int MAX_VERTICES = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  scc_pkg::dp_cmd_t                   cmd,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]  n_eff,
	input  logic                               cfg_clr,
	input  logic [scc_pkg::VTX_W-1:0]          from_vertex,
	input  logic [scc_pkg::VTX_W-1:0]          to_vertex,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [scc_pkg::ID_W-1:0]           component_id,
	output logic [scc_pkg::TOTAL_W-1:0]        component_total,
	output scc_pkg::status_t                   status,
	output scc_pkg::dp_sts_t                   sts
);

	localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW    = $clog2(MAX_VERTICES + 1);
	localparam int STK_W = VW + NW;

	logic [MAX_VERTICES-1:0] adj_mem  [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] radj_mem [MAX_VERTICES];
	logic [STK_W-1:0]        stk_mem  [MAX_VERTICES];
	logic [VW-1:0]           fin_mem  [MAX_VERTICES];
	logic [scc_pkg::ID_W-1:0] comp_mem [MAX_VERTICES];

	logic [MAX_VERTICES-1:0] adj_row_q, radj_row_q;
	logic [STK_W-1:0]        stk_rd_q;
	logic [VW-1:0]           fin_rd_q;
	logic [scc_pkg::ID_W-1:0] comp_rd_q;
	logic [MAX_VERTICES-1:0] vis_q;

	logic [VW-1:0] a_q, b_q, cur_q, clr_q;
	logic [NW-1:0] root_q, scan_q, sp_q, fin_cnt_q, idx_q, cc_q;
	logic          rv_q;

	logic                   out_v_q;
	logic [scc_pkg::ID_W-1:0]    out_id_q;
	logic [scc_pkg::TOTAL_W-1:0] out_total_q;
	scc_pkg::status_t       out_st_q;

	logic [VW-1:0] a_idx, b_idx, scan_idx, stk_v;
	logic [NW-1:0] stk_next;
	logic [VW-1:0] adj_addr, radj_addr, mark_idx;
	logic          mark;

	assign a_idx    = VW'(from_vertex - scc_pkg::VTX_W'(1));
	assign b_idx    = VW'(to_vertex - scc_pkg::VTX_W'(1));
	assign scan_idx = scan_q[VW-1:0];
	assign stk_v    = stk_rd_q[STK_W-1:NW];
	assign stk_next = stk_rd_q[NW-1:0];

	assign adj_addr  = cmd.add_rd ? a_idx : cur_q;
	assign radj_addr = cmd.add_rd ? b_idx : cur_q;

	always_comb begin
		mark     = 1'b1;
		mark_idx = scan_idx;
		if (cmd.root_start)
			mark_idx = root_q[VW-1:0];
		else if (cmd.p2_root)
			mark_idx = fin_rd_q;
		else if (!(cmd.p1_push || cmd.p2_push))
			mark = 1'b0;
	end

	// adjacency rows: successors and predecessors
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			adj_mem[clr_q]  <= '0;
			radj_mem[clr_q] <= '0;
		end else if (cmd.add_wr) begin
			adj_mem[a_q]  <= adj_row_q | (MAX_VERTICES'(1) << b_q);
			radj_mem[b_q] <= radj_row_q | (MAX_VERTICES'(1) << a_q);
		end
		if (cmd.add_rd || cmd.row_rd) begin
			adj_row_q  <= adj_mem[adj_addr];
			radj_row_q <= radj_mem[radj_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.p1_push)
			stk_mem[sp_q[VW-1:0]] <= {cur_q, scan_q + NW'(1)};
		else if (cmd.p2_push)
			stk_mem[sp_q[VW-1:0]] <= {scan_idx, NW'(0)};
		if (cmd.pop_rd)
			stk_rd_q <= stk_mem[VW'(sp_q - NW'(1))];
		if (cmd.p1_finish)
			fin_mem[fin_cnt_q[VW-1:0]] <= cur_q;
		if (cmd.fin_rd)
			fin_rd_q <= fin_mem[VW'(idx_q - NW'(1))];
		if (cmd.p2_visit)
			comp_mem[cur_q] <= scc_pkg::ID_W'(cc_q);
		if (cmd.qry_rd)
			comp_rd_q <= comp_mem[a_idx];
		if (cmd.take) begin
			a_q <= a_idx;
			b_q <= b_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q     <= '0;
			clr_q     <= '0;
			root_q    <= '0;
			scan_q    <= '0;
			sp_q      <= '0;
			fin_cnt_q <= '0;
			idx_q     <= '0;
			cc_q      <= '0;
			cur_q     <= '0;
			rv_q      <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cmd.clr_start)
				clr_q <= '0;
			else if (cmd.clr_step)
				clr_q <= clr_q + VW'(1);

			if (cmd.p1_init || cmd.p2_init)
				vis_q <= '0;
			else if (mark)
				vis_q[mark_idx] <= 1'b1;

			if (cmd.p1_init)
				root_q <= '0;
			else if (cmd.root_skip)
				root_q <= root_q + NW'(1);

			if (cmd.p1_init)
				fin_cnt_q <= '0;
			else if (cmd.p1_finish)
				fin_cnt_q <= fin_cnt_q + NW'(1);

			if (cmd.root_start) begin
				cur_q  <= root_q[VW-1:0];
				scan_q <= '0;
				sp_q   <= '0;
			end else if (cmd.p1_push) begin
				cur_q  <= scan_idx;
				scan_q <= '0;
				sp_q   <= sp_q + NW'(1);
			end else if (cmd.p2_push) begin
				scan_q <= scan_q + NW'(1);
				sp_q   <= sp_q + NW'(1);
			end else if (cmd.pop_rd) begin
				sp_q <= sp_q - NW'(1);
			end else if (cmd.p1_restore) begin
				cur_q  <= stk_v;
				scan_q <= stk_next;
			end else if (cmd.p2_root) begin
				cur_q <= fin_rd_q;
			end else if (cmd.p2_take) begin
				cur_q <= stk_v;
			end else if (cmd.p2_visit) begin
				scan_q <= '0;
			end else if (cmd.scan_step) begin
				scan_q <= scan_q + NW'(1);
			end

			if (cmd.p2_init)
				idx_q <= fin_cnt_q;
			else if (cmd.fin_rd)
				idx_q <= idx_q - NW'(1);

			if (cmd.p2_init || cmd.invalidate || cfg_clr)
				cc_q <= '0;
			else if (cmd.cc_inc)
				cc_q <= cc_q + NW'(1);

			if (cmd.invalidate || cfg_clr || cmd.p1_init)
				rv_q <= 1'b0;
			else if (cmd.done)
				rv_q <= 1'b1;

			if (cmd.resp)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			out_id_q    <= cmd.resp_qry ? comp_rd_q : '0;
			out_total_q <= (rv_q || cmd.done) ? scc_pkg::TOTAL_W'(cc_q) : '0;
			out_st_q    <= cmd.resp_st;
		end
	end

	assign out_valid       = out_v_q;
	assign component_id    = out_id_q;
	assign component_total = out_total_q;
	assign status          = out_st_q;

	always_comb begin
		sts.a_ok     = (from_vertex != '0) && (32'(from_vertex) <= 32'(n_eff));
		sts.ab_ok    = sts.a_ok && (to_vertex != '0) && (32'(to_vertex) <= 32'(n_eff));
		sts.rv       = rv_q;
		sts.out_busy = out_v_q && !out_ready;
		sts.clr_last = (clr_q == VW'(MAX_VERTICES - 1));
		sts.root_end = (root_q == n_eff);
		sts.root_vis = vis_q[root_q[VW-1:0]];
		sts.scan_end = (scan_q == n_eff);
		sts.hit_rev  = radj_row_q[scan_idx] && !vis_q[scan_idx];
		sts.hit_fwd  = adj_row_q[scan_idx] && !vis_q[scan_idx];
		sts.sp_zero  = (sp_q == '0);
		sts.idx_zero = (idx_q == '0);
		sts.fin_vis  = vis_q[fin_rd_q];
	end

endmodule

// ===== rtl/core/strongly_connected_components.sv =====
// Compute: each depth-first pass scans a registered adjacency row one bit per cycle.
// Commands: one at a time; the next is taken as soon as the result register frees.
// Reset: asynchronous; a clearing pass then zeroes the matrix,
// with s_tready low meanwhile (configuration writes are still taken).
module strongly_connected_components #(
	parameter int MAX_VERTICES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// command stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [scc_pkg::S_TDATA_W-1:0]     s_tdata,  // cmd[1:0], from_vertex[10:2], to_vertex[19:11]
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [scc_pkg::M_TDATA_W-1:0]     m_tdata   // component_id[7:0], component_total[16:8], status[18:17]
);

	localparam int NW = $clog2(MAX_VERTICES + 1);

	logic [scc_pkg::CFG_W-1:0] vertex_count_q;
	logic                      cfg_wr;
	logic [NW-1:0]             n_eff;

	scc_pkg::dp_cmd_t cmd;
	scc_pkg::dp_sts_t sts;
	scc_pkg::cmd_t    op;

	logic [scc_pkg::ID_W-1:0]    component_id;
	logic [scc_pkg::TOTAL_W-1:0] component_total;
	scc_pkg::status_t            status;

	// register file: only vertex_count at address 0
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
	assign prdata = (paddr == 3'd0) ? 32'(vertex_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vertex_count_q <= scc_pkg::CFG_W'(1);
		else if (cfg_wr)
			vertex_count_q <= pwdata[scc_pkg::CFG_W-1:0];
	end

	// zero acts as one, above capacity clamps to capacity
	always_comb begin
		if (vertex_count_q == '0)
			n_eff = NW'(1);
		else if (32'(vertex_count_q) > 32'(MAX_VERTICES))
			n_eff = NW'(MAX_VERTICES);
		else
			n_eff = NW'(vertex_count_q);
	end

	assign op = scc_pkg::cmd_t'(s_tdata[1:0]);

	scc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.op       (op),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	scc_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.n_eff           (n_eff),
		.cfg_clr         (cfg_wr),
		.from_vertex     (s_tdata[10:2]),
		.to_vertex       (s_tdata[19:11]),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.component_id    (component_id),
		.component_total (component_total),
		.status          (status),
		.sts             (sts)
	);

	assign m_tdata = {5'd0, status, component_total, component_id};

endmodule

// ===== sim/strongly_connected_components_test.sv =====
`timescale 1ns / 100ps

// Checks the SCC block by comparing every result transfer against a software
// Kosaraju predictor kept in step with each accepted command transfer.
module strongly_connected_components_test;

	localparam int MAXV = 256;

	typedef struct {
		logic [scc_pkg::ID_W-1:0]    id;
		logic [scc_pkg::TOTAL_W-1:0] total;
		scc_pkg::status_t            st;
	} scc_result_t;

	// predictor plus the queue of results still owed by the block
	class component_predictor;
		bit          adj [MAXV][MAXV];  // adj[u-1][w-1]: edge u -> w
		int unsigned vcount;
		bit          valid;
		int unsigned ccount;
		int unsigned comp_of [MAXV+1];
		scc_result_t expected_results [$];
		int          mismatches;
		int          failures;

		function new();
			vcount = 1;
		endfunction

		function int unsigned eff();
			if (vcount == 0) return 1;
			if (vcount > MAXV) return MAXV;
			return vcount;
		endfunction

		function void note_config(int unsigned v);
			vcount = v & 9'h1FF;
			valid  = 0;
			ccount = 0;
		endfunction

		function void compute();
			int          n, r, sp, u, w, s, fc, i;
			bit          pushed;
			int          ford [MAXV];
			int          stv [MAXV];
			int          stn [MAXV];
			bit          vis [MAXV+1];
			n  = eff();
			fc = 0;
			foreach (vis[k]) vis[k] = 0;
			// pass one: reversed edges, record finish order
			for (r = 1; r <= n; r++) begin
				if (vis[r]) continue;
				vis[r] = 1;
				stv[0] = r;
				stn[0] = 1;
				sp = 1;
				while (sp > 0) begin
					u = stv[sp-1];
					pushed = 0;
					for (w = stn[sp-1]; w <= n; w++) begin
						if (adj[w-1][u-1] && !vis[w]) begin
							stn[sp-1] = w + 1;
							vis[w] = 1;
							if (sp < MAXV) begin
								stv[sp] = w;
								stn[sp] = 1;
								sp++;
							end
							pushed = 1;
							break;
						end
					end
					if (!pushed) begin
						sp--;
						if (fc < MAXV) begin
							ford[fc] = u;
							fc++;
						end
					end
				end
			end
			// pass two: forward edges, latest finisher first
			foreach (vis[k]) vis[k] = 0;
			ccount = 0;
			for (i = fc; i > 0; i--) begin
				s = ford[i-1];
				if (s == 0 || s > n || vis[s]) continue;
				vis[s] = 1;
				stv[0] = s;
				sp = 1;
				while (sp > 0) begin
					sp--;
					u = stv[sp];
					comp_of[u] = ccount;
					for (w = 1; w <= n; w++) begin
						if (adj[u-1][w-1] && !vis[w]) begin
							vis[w] = 1;
							if (sp < MAXV) begin
								stv[sp] = w;
								sp++;
							end
						end
					end
				end
				ccount++;
			end
			valid = 1;
		endfunction

		function void note_command(scc_pkg::cmd_t cmd, int unsigned a, int unsigned b);
			scc_result_t res;
			int unsigned n;
			n = eff();
			res.id = '0;
			res.st = scc_pkg::ST_OK;
			case (cmd)
				scc_pkg::CMD_CLEAR: begin
					foreach (adj[x, y]) adj[x][y] = 0;
					valid  = 0;
					ccount = 0;
				end
				scc_pkg::CMD_ADD: begin
					if (a == 0 || a > n || b == 0 || b > n) res.st = scc_pkg::ST_RANGE;
					else begin
						adj[a-1][b-1] = 1;
						valid  = 0;
						ccount = 0;
					end
				end
				scc_pkg::CMD_COMPUTE: compute();
				default: begin
					if (a == 0 || a > n) res.st = scc_pkg::ST_RANGE;
					else if (!valid) res.st = scc_pkg::ST_NOT_READY;
					else res.id = comp_of[a][scc_pkg::ID_W-1:0];
				end
			endcase
			res.total = valid ? ccount[scc_pkg::TOTAL_W-1:0] : '0;
			expected_results = {expected_results, res};
		endfunction

		function void check_result(logic [scc_pkg::M_TDATA_W-1:0] data);
			scc_result_t want;
			logic [scc_pkg::ID_W-1:0]    got_id;
			logic [scc_pkg::TOTAL_W-1:0] got_total;
			logic [1:0]                  got_st;
			got_id    = data[7:0];
			got_total = data[16:8];
			got_st    = data[18:17];
			if (expected_results.size() == 0) begin
				failures++;
				$display("unexpected result transfer %h", data);
				return;
			end
			want = expected_results.pop_front();
			if (got_id !== want.id || got_total !== want.total || got_st !== want.st) begin
				mismatches++;
				failures++;
				if (mismatches <= 10)
					$display("expected id %0d total %0d st %0d, got id %0d total %0d st %0d",
						want.id, want.total, want.st, got_id, got_total, got_st);
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          psel, penable, pwrite;
	logic [2:0]                    paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [scc_pkg::S_TDATA_W-1:0] s_tdata;  // cmd[1:0], from_vertex[10:2], to_vertex[19:11]
	logic                          m_tvalid;
	logic                          m_tready;
	// component_id[7:0], component_total[16:8], status[18:17]
	logic [scc_pkg::M_TDATA_W-1:0] m_tdata;

	component_predictor pred;
	bit calm;          // no idling in the final stretch
	bit hold_off_req;  // asks the receiver for one long stall
	int stall_left;

	strongly_connected_components dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	// hard stop; two full-size computes plus stalls fit well inside this
	initial begin
		#60_000_000;
		$display("strongly_connected_components regression: fail");
		$finish;
	end

	// result side: check each transfer, stall in random bursts
	initial begin
		m_tready = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) pred.check_result(m_tdata);
			if (hold_off_req) begin
				hold_off_req = 0;
				stall_left = 400;  // long enough for the block to back up its input
			end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 16);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	// one command transfer; valid stays up when the next item follows directly
	task automatic send(scc_pkg::cmd_t cmd, int unsigned a, int unsigned b);
		s_tdata  <= {4'd0, b[8:0], a[8:0], cmd};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pred.note_command(cmd, a, b);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pred.expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);  // block may still be finishing its last command
	endtask

	// register write: setup then access cycle
	task automatic set_vertex_count(int unsigned v);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= '0;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pred.note_config(v);
	endtask

	// mostly legal vertices, sometimes any 9-bit value
	function automatic int unsigned pick(int unsigned n);
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 511);
		return $urandom_range(1, n);
	endfunction

	// random graph build, compute and queries with a little noise mixed in
	task automatic random_graph(int unsigned n, int edges, int queries);
		send(scc_pkg::CMD_CLEAR, $urandom_range(0, 511), $urandom_range(0, 511));
		repeat (edges) send(scc_pkg::CMD_ADD, pick(n), pick(n));
		if ($urandom_range(0, 4) == 0) send(scc_pkg::CMD_QUERY, pick(n), 0);  // stale query
		send(scc_pkg::CMD_COMPUTE, $urandom_range(0, 511), $urandom_range(0, 511));
		repeat (queries) begin
			if ($urandom_range(0, 7) == 0)
				send(scc_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 511),
					$urandom_range(0, 511));
			else
				send(scc_pkg::CMD_QUERY, pick(n), $urandom_range(0, 511));
		end
	endtask

	initial begin
		int unsigned n;
		pred = new();
		clk = 0;
		arst_n = 0;
		calm = 0;
		hold_off_req = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		s_tvalid = 0; s_tdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset count of one: stale query, range checks, self loop
		send(scc_pkg::CMD_QUERY, 1, 0);
		send(scc_pkg::CMD_QUERY, 0, 0);
		send(scc_pkg::CMD_ADD, 0, 1);
		send(scc_pkg::CMD_ADD, 1, 2);
		send(scc_pkg::CMD_ADD, 1, 1);
		send(scc_pkg::CMD_COMPUTE, 0, 0);
		send(scc_pkg::CMD_QUERY, 1, 0);
		send(scc_pkg::CMD_QUERY, 2, 0);
		send(scc_pkg::CMD_CLEAR, 0, 0);
		send(scc_pkg::CMD_QUERY, 1, 0);

		// zero acts as one
		set_vertex_count(0);
		send(scc_pkg::CMD_COMPUTE, 511, 511);
		send(scc_pkg::CMD_QUERY, 1, 511);

		// small graph: two directed loops, duplicate edge, config write drops results
		set_vertex_count(8);
		send(scc_pkg::CMD_ADD, 1, 2);
		send(scc_pkg::CMD_ADD, 2, 3);
		send(scc_pkg::CMD_ADD, 3, 1);
		send(scc_pkg::CMD_ADD, 3, 1);
		send(scc_pkg::CMD_ADD, 4, 5);
		send(scc_pkg::CMD_ADD, 5, 4);
		send(scc_pkg::CMD_ADD, 511, 511);
		send(scc_pkg::CMD_ADD, 256, 1);
		send(scc_pkg::CMD_COMPUTE, 0, 0);
		send(scc_pkg::CMD_QUERY, 8, 0);
		send(scc_pkg::CMD_QUERY, 3, 0);
		send(scc_pkg::CMD_QUERY, 511, 0);
		set_vertex_count(8);
		send(scc_pkg::CMD_QUERY, 1, 0);

		// above the maximum acts as 256; long receiver stall during this phase
		set_vertex_count(511);
		hold_off_req = 1;
		send(scc_pkg::CMD_CLEAR, 0, 0);
		send(scc_pkg::CMD_ADD, 256, 1);
		send(scc_pkg::CMD_ADD, 1, 256);
		send(scc_pkg::CMD_ADD, 255, 256);
		send(scc_pkg::CMD_COMPUTE, 0, 0);
		send(scc_pkg::CMD_QUERY, 256, 0);
		send(scc_pkg::CMD_QUERY, 257, 0);
		send(scc_pkg::CMD_QUERY, 1, 0);
		send(scc_pkg::CMD_QUERY, 128, 0);
		send(scc_pkg::CMD_QUERY, 255, 0);

		// edges beyond a shrunken count are left out of compute
		set_vertex_count(4);
		send(scc_pkg::CMD_COMPUTE, 0, 0);
		send(scc_pkg::CMD_QUERY, 1, 0);

		for (int p = 0; p < 3; p++) begin
			n = $urandom_range(2, 12);
			set_vertex_count(n);
			random_graph(n, $urandom_range(3, 2 * n), $urandom_range(2, 5));
		end

		set_vertex_count(300);
		random_graph(256, 12, 3);

		calm = 1;
		n = $urandom_range(3, 10);
		set_vertex_count(n);
		random_graph(n, $urandom_range(4, 12), 4);

		s_tvalid <= 1'b0;
		while (pred.expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (pred.failures == 0 && pred.expected_results.size() == 0)
			$display("strongly_connected_components regression: pass");
		else
			$display("strongly_connected_components regression: fail");
		$finish;
	end
endmodule

// ===== strongly_connected_components.f =====
+incdir+rtl/core
rtl/core/scc_pkg.sv
rtl/core/scc_ctrl.sv
rtl/core/scc_dp.sv
rtl/core/strongly_connected_components.sv
sim/strongly_connected_components_test.sv
